@@ hdl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Initial chaining vector
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LENGTH_LANE = 6'd56;
    localparam logic [3:0] LEN_WORD_LO = 4'd14;
    localparam logic [3:0] LEN_WORD_HI = 4'd15;

    // Source of the byte written into the block store
    typedef enum logic [1:0] {
        BSEL_DATA = 2'd0,
        BSEL_PAD  = 2'd1,
        BSEL_ZERO = 2'd2
    } byte_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      wr_byte;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      wr_length;
        logic      load_work;
        logic      round_a;
        logic      round_b;
        logic      chain_add;
        logic      next_word;
        logic      msg_done;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic lane_wrap;    // next byte lane is the last of the block
        logic at_length;    // next byte lane is where the length goes
        logic round_last;   // round counter at 63
        logic word_last;    // digest word D is on the output
    } status_t;

    // Sine-derived additive constants
    function automatic logic [31:0] sine_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Per-round left rotate amount
    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used in round i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [9:0] w;
        case (i[5:4])
            2'd0:    w = {4'd0, i};
            2'd1:    w = 10'd5 * {4'd0, i} + 10'd1;
            2'd2:    w = 10'd3 * {4'd0, i} + 10'd5;
            default: w = 10'd7 * {4'd0, i};
        endcase
        return w[3:0];
    endfunction

endpackage

@@ hdl/md5_datapath.sv @@
// ----------------------------------------------------------------------------
// md5_datapath
// Block store, byte lane and bit counters, round unit, chaining words and
// digest output select.
// ----------------------------------------------------------------------------
module md5_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  md5_pkg::cmd_t    cmd,
    output md5_pkg::status_t status,
    input  logic [7:0]       data_byte,
    output logic [31:0]      digest_word,
    output logic [1:0]       word_index,
    output logic             last_word
);

    logic [31:0] block_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] work_reg  [4];
    logic [31:0] t_reg;
    logic [63:0] bit_count_reg;
    logic [5:0]  offset_reg;
    logic [5:0]  round_reg;
    logic [1:0]  word_idx_reg;

    logic [7:0]  byte_val;
    logic [31:0] t_next;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [63:0] rot_dbl;
    logic [31:0] b_next;

    // Byte source select
    always_comb
    begin
        case (cmd.byte_sel)
            md5_pkg::BSEL_DATA: byte_val = data_byte;
            md5_pkg::BSEL_PAD:  byte_val = md5_pkg::PAD_BYTE;
            default:            byte_val = 8'h00;
        endcase
    end

    // Block store, little-endian byte lanes
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            block_reg[offset_reg[5:2]][{offset_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
        else if (cmd.wr_length)
        begin
            block_reg[md5_pkg::LEN_WORD_LO] <= bit_count_reg[31:0];
            block_reg[md5_pkg::LEN_WORD_HI] <= bit_count_reg[63:32];
        end
    end

    // Byte lane and message bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            bit_count_reg <= '0;
        end
        else
        begin
            if (cmd.wr_byte)
            begin
                offset_reg <= offset_reg + 6'd1;
            end
            else if (cmd.wr_length || cmd.msg_done)
            begin
                offset_reg <= '0;
            end
            if (cmd.msg_done)
            begin
                bit_count_reg <= '0;
            end
            else if (cmd.count_bits)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
            end
        end
    end

    // Round, first half: a + K + M[g]
    assign t_next = work_reg[0] + md5_pkg::sine_const(round_reg)
                  + block_reg[md5_pkg::msg_index(round_reg)];

    // Round, second half: nonlinear function, rotate, add b
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[3] & work_reg[1]) | (~work_reg[3] & work_reg[2]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
    end

    assign sum_val = t_reg + f_val;
    assign rot_dbl = {sum_val, sum_val} << md5_pkg::rot_amount(round_reg);
    assign b_next  = work_reg[1] + rot_dbl[63:32];

    // Working registers and partial sum
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            work_reg <= chain_reg;
        end
        else if (cmd.round_b)
        begin
            work_reg[0] <= work_reg[3];
            work_reg[1] <= b_next;
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
        end
        if (cmd.round_a)
        begin
            t_reg <= t_next;
        end
    end

    // Round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
        end
        else if (cmd.round_b)
        begin
            round_reg <= round_reg + 6'd1;
        end
    end

    // Chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
        end
        else if (cmd.msg_done)
        begin
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
        end
        else if (cmd.chain_add)
        begin
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_reg[k] + work_reg[k];
            end
        end
    end

    // Output word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_idx_reg <= '0;
        end
        else if (cmd.next_word)
        begin
            word_idx_reg <= word_idx_reg + 2'd1;
        end
    end

    assign digest_word = chain_reg[word_idx_reg];
    assign word_index  = word_idx_reg;
    assign last_word   = &word_idx_reg;

    // Status back to the controller
    assign status.lane_wrap  = &offset_reg;
    assign status.at_length  = (offset_reg == md5_pkg::LENGTH_LANE);
    assign status.round_last = &round_reg;
    assign status.word_last  = &word_idx_reg;

endmodule

@@ hdl/md5_ctrl.sv @@
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, padding, length insertion, the round loop and
// digest word hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             has_byte,
    input  logic             is_last,
    output logic             out_valid,
    input  logic             out_ready,
    output md5_pkg::cmd_t    cmd,
    input  md5_pkg::status_t status
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PAD   = 8'b0000_0010,
        S_ZERO  = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_RND_A = 8'b0001_0000,
        S_RND_B = 8'b0010_0000,
        S_FOLD  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    // Where to go once a block compression finishes
    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_ZERO = 2'd2,
        RET_EMIT = 2'd3
    } resume_t;

    state_t  state_reg,  state_next;
    resume_t resume_reg, resume_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resume_reg <= RET_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        cmd         = '0;
        cmd.byte_sel = md5_pkg::BSEL_DATA;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte)
                    begin
                        cmd.wr_byte    = 1'b1;
                        cmd.count_bits = 1'b1;
                    end
                    if (has_byte && status.lane_wrap)
                    begin
                        resume_next = is_last ? RET_PAD : RET_IDLE;
                        state_next  = S_LOAD;
                    end
                    else if (is_last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = md5_pkg::BSEL_PAD;
                if (status.lane_wrap)
                begin
                    resume_next = RET_ZERO;
                    state_next  = S_LOAD;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (status.at_length)
                begin
                    cmd.wr_length = 1'b1;
                    resume_next   = RET_EMIT;
                    state_next    = S_LOAD;
                end
                else
                begin
                    cmd.wr_byte  = 1'b1;
                    cmd.byte_sel = md5_pkg::BSEL_ZERO;
                    if (status.lane_wrap)
                    begin
                        resume_next = RET_ZERO;
                        state_next  = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = S_RND_A;
            end
            S_RND_A:
            begin
                cmd.round_a = 1'b1;
                state_next  = S_RND_B;
            end
            S_RND_B:
            begin
                cmd.round_b = 1'b1;
                state_next  = status.round_last ? S_FOLD : S_RND_A;
            end
            S_FOLD:
            begin
                cmd.chain_add = 1'b1;
                case (resume_reg)
                    RET_IDLE: state_next = S_IDLE;
                    RET_PAD:  state_next = S_PAD;
                    RET_ZERO: state_next = S_ZERO;
                    RET_EMIT: state_next = S_EMIT;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.next_word = 1'b1;
                    if (status.word_last)
                    begin
                        cmd.msg_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/md5_message_digest.sv @@
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per input word, four 32-bit digest
// words out per message.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | data_byte[7:0], has_byte, is_last
//  out     | out_valid / out_ready | digest_word[31:0], word_index[1:0],
//          |                       | last_word
//
//  A byte word that does not fill a block is written and intake stays ready;
//  one that fills it starts a compression: a load, 64 rounds of a first and
//  second half each, then a fold. An end word adds a pad byte, zero bytes up
//  to lane 56, the length, one or two compressions, then four output words.
//  No input is taken while a block compresses or the digest is handed out;
//  out_ready low holds the current word. Reset loads the initial vector.
//
module md5_message_digest
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    md5_pkg::cmd_t    cmd;
    md5_pkg::status_t status;

    md5_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    md5_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (data_byte),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // Intake and digest hand-off never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input ready while digest word pending");

    // An end word always leads to padding work, never straight back to ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_last |=> !in_ready)
    else $error("end word did not start padding");

    // Digest words come out in order A, B, C, D
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == $past(word_index) + 2'd1))
    else $error("digest word order broken");

    // After word D the block is ready for the next message
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("not ready after final digest word");

endmodule
